/* hw/rtl/pws_pkg.sv */
// Shared types and constants for the point window smoother.
package pws_pkg;

  localparam int MAX_DEPTH  = 8;
  localparam int COORD_BITS = 32;

  localparam int NUM_LANES  = 3;
  localparam int AGE_BITS   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CNT_BITS   = 4;
  localparam int WGT_BITS   = 16;
  localparam int FRAC_BITS  = 15;
  localparam int PROD_BITS  = COORD_BITS + WGT_BITS + 1;
  localparam int ACC_BITS   = PROD_BITS + AGE_BITS;
  localparam int MAG_BITS   = COORD_BITS + AGE_BITS;
  localparam int DIV_DIGIT  = 4;
  localparam int DIV_BITS   = ((MAG_BITS + DIV_DIGIT - 1) / DIV_DIGIT) * DIV_DIGIT;
  localparam int DIV_STEPS  = DIV_BITS / DIV_DIGIT;
  localparam int DSTEP_BITS = $clog2(DIV_STEPS + 1);

  localparam int CFG_BITS     = 64;
  localparam int CFG_IDX_BITS = 3;

  localparam logic [CFG_IDX_BITS-1:0] CFG_MODE       = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_LEN = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] CFG_WEIGHTS_LO = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] CFG_WEIGHTS_HI = CFG_IDX_BITS'(3);

  localparam logic [1:0] MODE_NEWEST   = 2'd0;
  localparam logic [1:0] MODE_MEAN     = 2'd1;
  localparam logic [1:0] MODE_WEIGHTED = 2'd2;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x_in;
    logic signed [COORD_BITS-1:0] y_in;
    logic signed [COORD_BITS-1:0] z_in;
  } pws_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x_out;
    logic signed [COORD_BITS-1:0] y_out;
    logic signed [COORD_BITS-1:0] z_out;
    logic        [CNT_BITS-1:0]   filled_count;
  } pws_out_t;

endpackage

/* hw/rtl/point_window_smoother_core.sv */
// Point window smoother: ring window memory, per-age MAC walk and mean divider.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------
//  in_     | input     | in_valid / in_stall   | pws_in_t  (x_in, y_in, z_in)
//  out_    | output    | out_valid / out_stall | pws_out_t (x/y/z_out, filled_count)
//  cfg_    | input     | cfg_we                | cfg_index, cfg_data (64 bits)
//
// One point is worked on at a time. It is written to the window RAM, then read back once
// per age through the single read port: fill reads in mean and weighted modes, one read
// otherwise. in_stall stays high from a transfer through the reads, the multiply and
// accumulate registers, the divider in mean mode and the output load, held by out_stall.
// Reset clears the control registers; the RAM is not swept, the fill count masks it.
// A waiting result sits in the output register; the next point is taken meanwhile.
module point_window_smoother_core
  import pws_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  pws_in_t                 in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output pws_out_t                out_data,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_DIV, S_FIN} state_t;

  localparam logic signed [ACC_BITS-1:0] COORD_MAX =
    {{(ACC_BITS-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] COORD_MIN =
    {{(ACC_BITS-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};
  localparam logic signed [ACC_BITS-1:0] ROUND_ADJ =
    {{(ACC_BITS-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};
  localparam logic signed [ACC_BITS-1:0] ACC_ZERO = ACC_BITS'(0);

  // control registers
  state_t                  state_r, state_nxt;
  logic [1:0]              mode_r, mode_nxt;
  logic [CNT_BITS-1:0]     win_len_r, win_len_nxt;
  logic [2*CFG_BITS-1:0]   wgt_r, wgt_nxt;
  logic [AGE_BITS-1:0]     write_slot_r, write_slot_nxt;
  logic [CNT_BITS-1:0]     fill_r, fill_nxt;
  logic [CNT_BITS-1:0]     n_reads_r, n_reads_nxt;
  logic [CNT_BITS-1:0]     iss_cnt_r, iss_cnt_nxt;
  logic                    rd_vld_r, rd_vld_nxt;
  logic                    mul_vld_r, mul_vld_nxt;
  logic [DSTEP_BITS-1:0]   dstep_r, dstep_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // datapath
  pws_in_t                       win_mem [MAX_DEPTH];
  pws_in_t                       mem_q_r;
  logic [AGE_BITS-1:0]           newest_r;
  logic signed [WGT_BITS:0]      wgt_d_r;
  logic signed [PROD_BITS-1:0]   prod_r [NUM_LANES];
  logic signed [ACC_BITS-1:0]    acc_r  [NUM_LANES];
  logic [DIV_BITS-1:0]           dvd_r  [NUM_LANES];
  logic [CNT_BITS:0]             rem_r  [NUM_LANES];
  logic                          neg_r  [NUM_LANES];
  pws_out_t                      out_data_r;

  logic                          in_xfer;
  logic                          rd_en;
  logic                          read_done;
  logic                          out_ld;
  logic [AGE_BITS-1:0]           rd_age;
  logic [CNT_BITS:0]             rd_addr_w;
  logic [AGE_BITS-1:0]           rd_addr;
  logic signed [WGT_BITS:0]      rd_wgt;
  logic [CNT_BITS-1:0]           len_cfg;
  logic signed [COORD_BITS-1:0]  lane_pt  [NUM_LANES];
  logic signed [ACC_BITS-1:0]    lane_res [NUM_LANES];
  logic signed [COORD_BITS-1:0]  lane_sat [NUM_LANES];
  logic [CNT_BITS+DIV_BITS:0]    div_nxt  [NUM_LANES];
  logic [ACC_BITS-1:0]           acc_mag  [NUM_LANES];

  // Restoring division, DIV_DIGIT quotient bits per call; quotient shifts into dvd.
  function automatic logic [CNT_BITS+DIV_BITS:0] div_step(
    input logic [CNT_BITS:0]   rem,
    input logic [DIV_BITS-1:0] dvd,
    input logic [CNT_BITS-1:0] den
  );
    logic [CNT_BITS:0]   r;
    logic [DIV_BITS-1:0] d;
    r = rem;
    d = dvd;
    for (int k = 0; k < DIV_DIGIT; k++) begin
      r = {r[CNT_BITS-1:0], d[DIV_BITS-1]};
      d = {d[DIV_BITS-2:0], 1'b0};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        d[0] = 1'b1;
      end
    end
    return {r, d};
  endfunction

  function automatic logic signed [COORD_BITS-1:0] sat_coord(
    input logic signed [ACC_BITS-1:0] v
  );
    logic signed [ACC_BITS-1:0] c;
    c = v;
    if (v > COORD_MAX) begin
      c = COORD_MAX;
    end else if (v < COORD_MIN) begin
      c = COORD_MIN;
    end
    return c[COORD_BITS-1:0];
  endfunction

  assign in_stall  = !rst_n || (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign rd_en     = (state_r == S_READ) && (iss_cnt_r < n_reads_r);
  assign read_done = (state_r == S_READ) && (iss_cnt_r == n_reads_r) &&
                     !rd_vld_r && !mul_vld_r;
  assign out_ld    = (state_r == S_FIN) && (!out_valid_r || !out_stall);

  // ring address of the entry with the given age, newest first
  assign rd_age    = iss_cnt_r[AGE_BITS-1:0];
  always_comb begin
    if ((CNT_BITS+1)'(newest_r) >= (CNT_BITS+1)'(rd_age)) begin
      rd_addr_w = (CNT_BITS+1)'(newest_r) - (CNT_BITS+1)'(rd_age);
    end else begin
      rd_addr_w = (CNT_BITS+1)'(newest_r) + {1'b0, win_len_r} - (CNT_BITS+1)'(rd_age);
    end
  end
  assign rd_addr = rd_addr_w[AGE_BITS-1:0];

  assign rd_wgt = (mode_r == MODE_WEIGHTED) ?
                  $signed({1'b0, wgt_r[WGT_BITS*int'(rd_age) +: WGT_BITS]}) :
                  (WGT_BITS+1)'(1);

  always_comb begin
    len_cfg = cfg_data[CNT_BITS-1:0];
    if (len_cfg == '0) begin
      len_cfg = CNT_BITS'(1);
    end else if (len_cfg > CNT_BITS'(MAX_DEPTH)) begin
      len_cfg = CNT_BITS'(MAX_DEPTH);
    end
  end

  assign lane_pt[0] = mem_q_r.x_in;
  assign lane_pt[1] = mem_q_r.y_in;
  assign lane_pt[2] = mem_q_r.z_in;

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      div_nxt[l] = div_step(rem_r[l], dvd_r[l], fill_r);
      acc_mag[l] = acc_r[l][ACC_BITS-1] ? ACC_BITS'(-acc_r[l]) : ACC_BITS'(acc_r[l]);
      unique case (mode_r)
        MODE_WEIGHTED: begin
          // truncate toward zero: bias negatives before the arithmetic shift
          lane_res[l] = (acc_r[l] + (acc_r[l][ACC_BITS-1] ? ROUND_ADJ : ACC_ZERO))
                        >>> FRAC_BITS;
        end
        MODE_MEAN: begin
          lane_res[l] = neg_r[l] ? -$signed(ACC_BITS'(dvd_r[l])) :
                                   $signed(ACC_BITS'(dvd_r[l]));
        end
        default: begin
          lane_res[l] = acc_r[l];
        end
      endcase
      lane_sat[l] = sat_coord(lane_res[l]);
    end
  end

  // control next state
  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    win_len_nxt    = win_len_r;
    wgt_nxt        = wgt_r;
    write_slot_nxt = write_slot_r;
    fill_nxt       = fill_r;
    n_reads_nxt    = n_reads_r;
    iss_cnt_nxt    = iss_cnt_r;
    rd_vld_nxt     = rd_en;
    mul_vld_nxt    = rd_vld_r;
    dstep_nxt      = dstep_r;
    out_valid_nxt  = out_ld || (out_valid_r && out_stall);

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE: begin
          mode_nxt       = cfg_data[1:0];
          write_slot_nxt = '0;
          fill_nxt       = '0;
        end
        CFG_WINDOW_LEN: begin
          win_len_nxt    = len_cfg;
          write_slot_nxt = '0;
          fill_nxt       = '0;
        end
        CFG_WEIGHTS_LO: wgt_nxt[CFG_BITS-1:0]          = cfg_data;
        CFG_WEIGHTS_HI: wgt_nxt[2*CFG_BITS-1:CFG_BITS] = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if ((CNT_BITS)'(write_slot_r) + CNT_BITS'(1) == win_len_r) begin
            write_slot_nxt = '0;
          end else begin
            write_slot_nxt = write_slot_r + AGE_BITS'(1);
          end
          fill_nxt = (fill_r < win_len_r) ? fill_r + CNT_BITS'(1) : win_len_r;
          if (mode_r == MODE_MEAN || mode_r == MODE_WEIGHTED) begin
            n_reads_nxt = fill_nxt;
          end else begin
            n_reads_nxt = CNT_BITS'(1);
          end
          iss_cnt_nxt = '0;
          state_nxt   = S_READ;
        end
      end
      S_READ: begin
        if (rd_en) begin
          iss_cnt_nxt = iss_cnt_r + CNT_BITS'(1);
        end
        if (read_done) begin
          dstep_nxt = '0;
          state_nxt = (mode_r == MODE_MEAN) ? S_DIV : S_FIN;
        end
      end
      S_DIV: begin
        dstep_nxt = dstep_r + DSTEP_BITS'(1);
        if (dstep_r == DSTEP_BITS'(DIV_STEPS - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_ld) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mode_r       <= MODE_NEWEST;
      win_len_r    <= CNT_BITS'(MAX_DEPTH);
      wgt_r        <= '0;
      write_slot_r <= '0;
      fill_r       <= '0;
      n_reads_r    <= '0;
      iss_cnt_r    <= '0;
      rd_vld_r     <= 1'b0;
      mul_vld_r    <= 1'b0;
      dstep_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mode_r       <= mode_nxt;
      win_len_r    <= win_len_nxt;
      wgt_r        <= wgt_nxt;
      write_slot_r <= write_slot_nxt;
      fill_r       <= fill_nxt;
      n_reads_r    <= n_reads_nxt;
      iss_cnt_r    <= iss_cnt_nxt;
      rd_vld_r     <= rd_vld_nxt;
      mul_vld_r    <= mul_vld_nxt;
      dstep_r      <= dstep_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Window RAM. Reads start the cycle after the write, and the next point waits
  // for this one to finish, so write and read never collide on an entry.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      win_mem[write_slot_r] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q_r <= win_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      newest_r <= write_slot_r;
    end
    if (rd_en) begin
      wgt_d_r <= rd_wgt;
    end
    for (int l = 0; l < NUM_LANES; l++) begin
      if (rd_vld_r) begin
        prod_r[l] <= lane_pt[l] * wgt_d_r;
      end
      if (in_xfer) begin
        acc_r[l] <= '0;
      end else if (mul_vld_r) begin
        acc_r[l] <= acc_r[l] + ACC_BITS'(prod_r[l]);
      end
      if (read_done) begin
        dvd_r[l] <= acc_mag[l][DIV_BITS-1:0];
        rem_r[l] <= '0;
        neg_r[l] <= acc_r[l][ACC_BITS-1];
      end else if (state_r == S_DIV) begin
        dvd_r[l] <= div_nxt[l][DIV_BITS-1:0];
        rem_r[l] <= div_nxt[l][CNT_BITS+DIV_BITS:DIV_BITS];
      end
    end
    if (out_ld) begin
      out_data_r.x_out        <= lane_sat[0];
      out_data_r.y_out        <= lane_sat[1];
      out_data_r.z_out        <= lane_sat[2];
      out_data_r.filled_count <= fill_r;
    end
  end

endmodule

/* hw/rtl/pws_checker.sv */
// Port-level checks for the point window smoother, bound to the top level.
module pws_checker
  import pws_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input pws_out_t                out_data
);

  logic       in_xfer;
  logic       out_xfer;
  logic [1:0] pend_r;
  logic [1:0] pend_nxt;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  always_comb begin
    pend_nxt = pend_r;
    if (in_xfer && !out_xfer) begin
      pend_nxt = pend_r + 2'd1;
    end else if (!in_xfer && out_xfer) begin
      pend_nxt = pend_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // busy right after taking a point
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> in_stall)
    else $error("input taken while previous point still in work");

  // at most one point in work plus one result waiting
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("too many points in flight");

  a_no_spurious_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result without a pending point");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind point_window_smoother_core pws_checker u_pws_checker (.*);

/* test/pws_smoothing_checker.sv */
// Result checker for point_window_smoother_core: tracks config, predicts and compares.
`timescale 1ns / 1ps

module pws_smoothing_checker
  import pws_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  pws_in_t                 in_data,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  pws_out_t                out_data,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data,
  output int                      mismatches,
  output int                      awaited
);

  logic [1:0]                   mode_r;
  int unsigned                  win_len;
  logic [CFG_BITS-1:0]          wgt_lo;
  logic [CFG_BITS-1:0]          wgt_hi;
  logic signed [COORD_BITS-1:0] ring [NUM_LANES][MAX_DEPTH];
  int unsigned                  slot;
  int unsigned                  fill;
  pws_out_t                     smoothed_q[$];
  int                           fail_count = 0;

  task automatic clear_window();
    foreach (ring[l, i]) ring[l][i] = '0;
    slot = 0;
    fill = 0;
  endtask

  function automatic longint weight_at(int unsigned age);
    logic [CFG_BITS-1:0] bank;
    bank = (age < 4) ? wgt_lo : wgt_hi;
    return {{(64-WGT_BITS){1'b0}}, bank[WGT_BITS*(age%4) +: WGT_BITS]};
  endfunction

  function automatic logic signed [COORD_BITS-1:0] clamp(longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (COORD_BITS-1)) - 1;
    lo = -hi - 1;
    v = (v > hi) ? hi : (v < lo) ? lo : v;
    return v[COORD_BITS-1:0];
  endfunction

  // Age 0 is the slot just written; older entries walk back around the ring.
  function automatic logic signed [COORD_BITS-1:0] lane_result(int lane, int unsigned newest);
    longint      acc;
    longint      pt;
    int unsigned idx;
    acc = 0;
    if (mode_r == MODE_MEAN || mode_r == MODE_WEIGHTED) begin
      for (int unsigned a = 0; a < fill; a++) begin
        idx = (newest + win_len - a) % win_len;
        pt = longint'(ring[lane][idx]);
        acc += (mode_r == MODE_MEAN) ? pt : pt * weight_at(a);
      end
      // signed division truncates toward zero in both cases
      acc = (mode_r == MODE_MEAN) ? acc / longint'(fill) : acc / (longint'(1) <<< FRAC_BITS);
    end else begin
      acc = longint'(ring[lane][newest]);
    end
    return clamp(acc);
  endfunction

  function automatic pws_out_t smooth_point(pws_in_t p);
    pws_out_t    r;
    int unsigned newest;
    newest = slot % win_len;
    ring[0][newest] = p.x_in;
    ring[1][newest] = p.y_in;
    ring[2][newest] = p.z_in;
    slot = (newest + 1) % win_len;
    fill = (fill < win_len) ? fill + 1 : win_len;
    r.x_out = lane_result(0, newest);
    r.y_out = lane_result(1, newest);
    r.z_out = lane_result(2, newest);
    r.filled_count = CNT_BITS'(fill);
    return r;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    pws_out_t    want;
    int unsigned len;
    if (!rst_n) begin
      mode_r = MODE_NEWEST;
      win_len = MAX_DEPTH;
      wgt_lo = '0;
      wgt_hi = '0;
      clear_window();
      smoothed_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODE: begin
            mode_r = cfg_data[1:0];
            clear_window();
          end
          CFG_WINDOW_LEN: begin
            len = 32'(cfg_data[CNT_BITS-1:0]);
            win_len = (len == 0) ? 1 : (len > MAX_DEPTH) ? MAX_DEPTH : len;
            clear_window();
          end
          CFG_WEIGHTS_LO: wgt_lo = cfg_data;
          CFG_WEIGHTS_HI: wgt_hi = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (smoothed_q.size() == 0) begin
          $error("result transfer with no point outstanding");
          fail_count++;
        end else begin
          want = smoothed_q.pop_front();
          check_field("x_out", longint'(want.x_out), longint'(out_data.x_out));
          check_field("y_out", longint'(want.y_out), longint'(out_data.y_out));
          check_field("z_out", longint'(want.z_out), longint'(out_data.z_out));
          check_field("filled_count", longint'(want.filled_count),
                      longint'(out_data.filled_count));
        end
      end
      if (in_valid && !in_stall) smoothed_q = {smoothed_q, smooth_point(in_data)};
    end
    mismatches <= fail_count;
    awaited <= smoothed_q.size();
  end

endmodule

/* test/tb_point_window_smoother_core.sv */
// Testbench top for point_window_smoother_core: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_point_window_smoother_core;
  import pws_pkg::*;

  localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNMAPPED   = CFG_WEIGHTS_HI + CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] CFG_LAST_INDEX = '1;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_e;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  pws_in_t                 in_data = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  pws_out_t                out_data;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = CFG_MODE;
  logic [CFG_BITS-1:0]     cfg_data = '0;
  int                      mismatches;
  int                      awaited;

  int           burst_left = 0;
  stall_style_e stall_style = STALL_NONE;
  int           style_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  point_window_smoother_core dut (.*);

  pws_smoothing_checker chk (.*);

  // Receiver: picks one of four stall styles at random and switches between them.
  always @(posedge clk) begin
    if (style_left == 0) begin
      stall_style = stall_style_e'($urandom_range(0, 3));
      style_left = $urandom_range(8, 80);
    end
    style_left--;
    case (stall_style)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= (style_left % 5) < 2;
    endcase
  end

  function automatic pws_in_t point(logic signed [COORD_BITS-1:0] x,
                                    logic signed [COORD_BITS-1:0] y,
                                    logic signed [COORD_BITS-1:0] z);
    pws_in_t p;
    p.x_in = x;
    p.y_in = y;
    p.z_in = z;
    return p;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] rand_coord();
    logic signed [COORD_BITS-1:0] c;
    c = $urandom;
    case ($urandom_range(0, 7))
      0:       c = C_MAX;
      1:       c = C_MIN;
      2, 3, 4: c = c >>> 12;   // within a few units of Q16.16
      default: ;
    endcase
    return c;
  endfunction

  function automatic logic [CFG_BITS-1:0] rand_weights();
    logic [CFG_BITS-1:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: w = '0;
      1: w = '1;
      2: w = {4{16'h8000}};
      3: for (int i = 0; i < 4; i++)
           w[WGT_BITS*i +: WGT_BITS] = WGT_BITS'($urandom_range(0, 16'h2000));
      default: ;
    endcase
    return w;
  endfunction

  // Holds the point until its transfer; the sender runs in bursts with gaps between.
  task automatic send_point(input pws_in_t p);
    int gap;
    in_data <= p;
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid && !in_stall));
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Drain every outstanding result, then let the pipeline go quiet.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited != 0);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int                  sent;
    int                  n;
    logic [CFG_BITS-1:0] v;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: newest point at the extremes
    send_point(point(C_MAX, C_MIN, '0));
    send_point(point(C_MIN, C_MAX, -1));
    settle();

    write_reg(CFG_MODE, CFG_BITS'(MODE_MEAN));
    write_reg(CFG_WINDOW_LEN, CFG_BITS'(3));
    send_point(point(C_MAX, C_MIN, 1));
    send_point(point(C_MAX, C_MIN, 2));
    send_point(point(C_MAX, C_MIN, -7));
    send_point(point(C_MIN, C_MAX, 5));
    settle();

    // full-scale weights push the weighted sum into both rails; length 15 clamps
    write_reg(CFG_WEIGHTS_LO, '1);
    write_reg(CFG_WEIGHTS_HI, '1);
    write_reg(CFG_MODE, CFG_BITS'(MODE_WEIGHTED));
    write_reg(CFG_WINDOW_LEN, CFG_BITS'(15));
    repeat (3) send_point(point(C_MAX, C_MIN, -1));
    settle();

    // tiny weights: small negative sums truncate toward zero, ring wraps at 4
    write_reg(CFG_WEIGHTS_LO, {4{16'h0001}});
    write_reg(CFG_WEIGHTS_HI, '0);
    write_reg(CFG_WINDOW_LEN, CFG_BITS'(4));
    for (int i = 0; i < 5; i++) send_point(point(-3 - i, 5 + i, -32768 * i));
    settle();

    // weight and unmapped writes leave the window contents alone
    write_reg(CFG_WEIGHTS_LO, {16'h8000, 16'h4000, 16'h2000, 16'h8000});
    write_reg(CFG_UNMAPPED, '1);
    write_reg(CFG_LAST_INDEX, '1);
    send_point(point(32'sh0001_0000, -32'sh0001_0000, 7));
    send_point(point(-1, 1, C_MIN));
    settle();

    write_reg(CFG_MODE, CFG_BITS'(MODE_UNUSED));
    write_reg(CFG_WINDOW_LEN, CFG_BITS'(0));
    send_point(point(C_MIN, 12345, C_MAX));
    send_point(point(-2, C_MAX, 0));
    settle();

    write_reg(CFG_MODE, CFG_BITS'(MODE_MEAN));
    write_reg(CFG_WINDOW_LEN, CFG_BITS'(1));
    send_point(point(C_MIN, -5, 9));
    send_point(point(C_MAX, 5, -9));

    sent = 0;
    while (sent < 950) begin
      settle();
      if ($urandom_range(0, 3) != 0) begin
        v = {$urandom, $urandom};
        v[1:0] = 2'($urandom_range(MODE_NEWEST, MODE_UNUSED));
        write_reg(CFG_MODE, v);
      end
      if ($urandom_range(0, 3) != 0) begin
        v = {$urandom, $urandom};
        v[CNT_BITS-1:0] = $urandom_range(0, 1) ? CNT_BITS'($urandom_range(1, MAX_DEPTH))
                                               : CNT_BITS'($urandom_range(0, 15));
        write_reg(CFG_WINDOW_LEN, v);
      end
      if ($urandom_range(0, 1) != 0) write_reg(CFG_WEIGHTS_LO, rand_weights());
      if ($urandom_range(0, 1) != 0) write_reg(CFG_WEIGHTS_HI, rand_weights());
      if ($urandom_range(0, 7) == 0)
        write_reg(CFG_IDX_BITS'($urandom_range(CFG_UNMAPPED, CFG_LAST_INDEX)),
                  {$urandom, $urandom});
      n = $urandom_range(10, 120);
      repeat (n) send_point(point(rand_coord(), rand_coord(), rand_coord()));
      sent += n;
    end

    settle();
    if (mismatches == 0) begin
      $display("** point_window_smoother_core: PASSED **");
    end else begin
      $display("** point_window_smoother_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("** point_window_smoother_core: FAILED **");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/pws_pkg.sv
hw/rtl/point_window_smoother_core.sv
hw/rtl/pws_checker.sv
test/pws_smoothing_checker.sv
test/tb_point_window_smoother_core.sv
